### rtl/srfc_pkg.sv
// shared types, constants and the crc-16 byte update for the reply frame checker
// no dependencies; used by every module of the block
`default_nettype none

package srfc_pkg;

   localparam int ByteWidth  = 8;
   localparam int WordWidth  = 16;
   localparam int PosWidth   = 3;
   localparam int IndexWidth = 8;

   localparam logic [WordWidth-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [WordWidth-1:0] CRC_POLY = 16'hA001;

   localparam logic [ByteWidth-1:0] FUNCTION_RESET = 8'd3;
   localparam logic [ByteWidth-1:0] COUNT_RESET    = 8'd4;

   // configuration register indexes
   localparam logic [IndexWidth-1:0] CSR_EXPECTED_FUNCTION = 8'd0;
   localparam logic [IndexWidth-1:0] CSR_EXPECTED_COUNT    = 8'd1;

   // byte positions within a reply frame
   localparam logic [PosWidth-1:0] POS_FUNCTION  = 3'd0;
   localparam logic [PosWidth-1:0] POS_COUNT     = 3'd1;
   localparam logic [PosWidth-1:0] POS_HUM_HIGH  = 3'd2;
   localparam logic [PosWidth-1:0] POS_HUM_LOW   = 3'd3;
   localparam logic [PosWidth-1:0] POS_TEMP_HIGH = 3'd4;
   localparam logic [PosWidth-1:0] POS_TEMP_LOW  = 3'd5;
   localparam logic [PosWidth-1:0] POS_CRC_LOW   = 3'd6;
   localparam logic [PosWidth-1:0] POS_CRC_HIGH  = 3'd7;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_HEADER_BAD = 2'd1,
      STATUS_CRC_BAD    = 2'd2
   } status_type;

   typedef struct packed {
      logic [WordWidth-1:0] humidity_tenths;
      logic [WordWidth-1:0] temperature_tenths;
      status_type           frame_status;
   } result_type;

   // one byte of the reflected modbus crc, bit at a time
   function automatic logic [WordWidth-1:0] crc_byte(input logic [WordWidth-1:0] crc,
                                                     input logic [ByteWidth-1:0] data);
      logic [WordWidth-1:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < ByteWidth; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/srfc_frame_core.sv
// per-byte frame state: position, running crc, header check and data words
// depends on srfc_pkg
`default_nettype none

module srfc_frame_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               step_en,
   input  wire logic [srfc_pkg::ByteWidth-1:0]     rx_byte,
   input  wire logic                               frame_begin,
   input  wire logic [srfc_pkg::ByteWidth-1:0]     expected_function,
   input  wire logic [srfc_pkg::ByteWidth-1:0]     expected_count,
   output logic                                    emit,
   output srfc_pkg::result_type                    result
);

   logic [srfc_pkg::PosWidth-1:0]  pos_ff, pos_in, pos_eff;
   logic [srfc_pkg::WordWidth-1:0] crc_ff, crc_in, crc_base, crc_next;
   logic                           hdr_ff, hdr_in, hdr_base;
   logic [srfc_pkg::WordWidth-1:0] hum_ff, hum_in;
   logic [srfc_pkg::WordWidth-1:0] temp_ff, temp_in;
   logic [srfc_pkg::ByteWidth-1:0] crc_low_ff, crc_low_in;
   logic [srfc_pkg::WordWidth-1:0] received;

   // frame begin rearms before the byte is used
   assign pos_eff  = frame_begin ? srfc_pkg::POS_FUNCTION : pos_ff;
   assign crc_base = frame_begin ? srfc_pkg::CRC_INIT : crc_ff;
   assign hdr_base = frame_begin ? 1'b1 : hdr_ff;
   assign crc_next = srfc_pkg::crc_byte(crc_base, rx_byte);
   assign received = {rx_byte, crc_low_ff};
   assign emit     = (pos_eff == srfc_pkg::POS_CRC_HIGH);

   always_comb begin
      result.humidity_tenths    = hum_ff;
      result.temperature_tenths = temp_ff;
      if (!hdr_base) begin
         result.frame_status = srfc_pkg::STATUS_HEADER_BAD;
      end else if (received != crc_base) begin
         result.frame_status = srfc_pkg::STATUS_CRC_BAD;
      end else begin
         result.frame_status = srfc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      hdr_in     = hdr_ff;
      hum_in     = hum_ff;
      temp_in    = temp_ff;
      crc_low_in = crc_low_ff;
      if (step_en) begin
         pos_in = pos_eff + 3'd1;
         crc_in = crc_next;
         hdr_in = hdr_base;
         case (pos_eff)
            srfc_pkg::POS_FUNCTION: begin
               if (rx_byte != expected_function) hdr_in = 1'b0;
            end
            srfc_pkg::POS_COUNT: begin
               if (rx_byte != expected_count) hdr_in = 1'b0;
            end
            srfc_pkg::POS_HUM_HIGH:  hum_in  = {rx_byte, hum_ff[7:0]};
            srfc_pkg::POS_HUM_LOW:   hum_in  = {hum_ff[15:8], rx_byte};
            srfc_pkg::POS_TEMP_HIGH: temp_in = {rx_byte, temp_ff[7:0]};
            srfc_pkg::POS_TEMP_LOW:  temp_in = {temp_ff[15:8], rx_byte};
            srfc_pkg::POS_CRC_LOW: begin
               crc_low_in = rx_byte;
               crc_in     = crc_base;
            end
            default: begin
               // last byte: result goes out, frame rearms
               pos_in = srfc_pkg::POS_FUNCTION;
               crc_in = srfc_pkg::CRC_INIT;
               hdr_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= srfc_pkg::POS_FUNCTION;
         crc_ff     <= srfc_pkg::CRC_INIT;
         hdr_ff     <= 1'b1;
         hum_ff     <= '0;
         temp_ff    <= '0;
         crc_low_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         hdr_ff     <= hdr_in;
         hum_ff     <= hum_in;
         temp_ff    <= temp_in;
         crc_low_ff <= crc_low_in;
      end
   end

endmodule

`default_nettype wire

### rtl/srfc_out_reg.sv
// result register between the frame core and the rsp stream
// depends on srfc_pkg
`default_nettype none

module srfc_out_reg (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire srfc_pkg::result_type load_data,
   output logic               can_load,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output srfc_pkg::result_type rsp_data
);

   logic                 full_ff, full_in;
   srfc_pkg::result_type data_ff, data_in;

   assign can_load   = !full_ff || rsp_tready;
   assign rsp_tvalid = full_ff;
   assign rsp_data   = data_ff;

   always_comb begin
      full_in = full_ff;
      data_in = data_ff;
      if (full_ff && rsp_tready) full_in = 1'b0;
      if (load) begin
         full_in = 1'b1;
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

### rtl/sensor_reply_frame_checker_unit.sv
// a frame's result goes from the input register to the result register, then out on rsp
// throughput: one byte per cycle; the rsp side only stalls req when a result is blocked
// reset (synchronous, active high) rearms the frame, empties both registers and
// loads expected function 3 and expected count 4
// depends on srfc_pkg, srfc_frame_core and srfc_out_reg
`default_nettype none

module sensor_reply_frame_checker_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [0:0]  req_tuser,   // [0] frame_begin
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths
   output logic [1:0]       rsp_tuser,   // [1:0] frame_status
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   // configuration registers
   logic [7:0] exp_function_ff, exp_function_in;
   logic [7:0] exp_count_ff, exp_count_in;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_begin_ff, in_begin_in;

   logic                 emit;
   logic                 can_load;
   logic                 advance;
   srfc_pkg::result_type core_result;
   srfc_pkg::result_type out_result;

   // register port always takes a write; unknown indexes drop out
   assign csr_ready = 1'b1;

   always_comb begin
      exp_function_in = exp_function_ff;
      exp_count_in    = exp_count_ff;
      if (csr_valid) begin
         case (csr_index)
            srfc_pkg::CSR_EXPECTED_FUNCTION: exp_function_in = csr_data;
            srfc_pkg::CSR_EXPECTED_COUNT:    exp_count_in    = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_function_ff <= srfc_pkg::FUNCTION_RESET;
         exp_count_ff    <= srfc_pkg::COUNT_RESET;
      end else begin
         exp_function_ff <= exp_function_in;
         exp_count_ff    <= exp_count_in;
      end
   end

   // the held byte moves on unless it completes a frame and the result slot is blocked
   assign advance    = in_valid_ff && (!emit || can_load);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_begin_in = in_begin_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_begin_in = req_tuser[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_begin_ff <= in_begin_in;
   end

   // crc, header check and word assembly for the held byte
   srfc_frame_core u_core (
      .clock             (clock),
      .reset             (reset),
      .step_en           (advance),
      .rx_byte           (in_byte_ff),
      .frame_begin       (in_begin_ff),
      .expected_function (exp_function_ff),
      .expected_count    (exp_count_ff),
      .emit              (emit),
      .result            (core_result)
   );

   // result register, refilled in the cycle its word is taken
   srfc_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && emit),
      .load_data  (core_result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (out_result)
   );

   assign rsp_tdata = {out_result.temperature_tenths, out_result.humidity_tenths};
   assign rsp_tuser = out_result.frame_status;

   // a blocked final byte keeps its place in the input register
   a_held_byte_stays: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_begin_ff))
      else $error("held byte lost while the result slot was blocked");

   // a completed frame always shows up on rsp next cycle
   a_frame_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> rsp_tvalid)
      else $error("completed frame produced no result word");

   // a write to the function register lands
   a_function_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == srfc_pkg::CSR_EXPECTED_FUNCTION
      |=> exp_function_ff == $past(csr_data))
      else $error("expected function write not applied");

endmodule

`default_nettype wire

### bench/sensor_reply_frame_checker_unit_tb.sv
// self-checking bench for sensor_reply_frame_checker_unit: drives reply bytes and register
// writes, predicts each frame verdict and compares every rsp word against it
// depends on srfc_pkg and the rtl of sensor_reply_frame_checker_unit
`timescale 1ns / 1ps

module sensor_reply_frame_checker_unit_tb;
   import srfc_pkg::*;

   // bytes of random traffic after the directed part
   localparam int RandomBytes = 700;
   // indexes past the register list, writes there must leave both registers alone
   localparam logic [IndexWidth-1:0] CSR_UNUSED_FIRST = CSR_EXPECTED_COUNT + 8'd1;
   localparam logic [IndexWidth-1:0] CSR_UNUSED_LAST  = 8'hFF;

   // clock, reset and every input of the block start at known values
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] rx_byte
   logic [0:0]  req_tuser  = '0;   // [0] frame_begin
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [31:0] rsp_tdata;         // [15:0] humidity_tenths, [31:16] temperature_tenths
   wire  [1:0]  rsp_tuser;         // [1:0] frame_status
   logic        csr_valid  = 1'b0;
   wire         csr_ready;
   logic [7:0]  csr_index  = '0;
   logic [7:0]  csr_data   = '0;

   // one frame verdict as the block should report it
   typedef struct packed {
      logic [WordWidth-1:0] humidity;
      logic [WordWidth-1:0] temperature;
      status_type           status;
   } reading_type;

   reading_type pending_readings[$];

   // predictor copy of the registers and of the frame state
   logic [ByteWidth-1:0] want_function;
   logic [ByteWidth-1:0] want_count;
   logic [PosWidth-1:0]  frame_pos;
   logic [WordWidth-1:0] crc_acc;
   logic                 header_ok;
   logic [WordWidth-1:0] hum_acc;
   logic [WordWidth-1:0] temp_acc;
   logic [ByteWidth-1:0] crc_low_byte;

   int errors     = 0;
   int bytes_sent = 0;

   // flow control knobs, cleared now and then to give stretches with no idling
   bit req_pauses_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int rsp_hold      = 0;
   int rsp_gap       = 0;

   sensor_reply_frame_checker_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // reflected modbus crc, one byte folded in lsb first
   function automatic logic [WordWidth-1:0] modbus_crc_step(input logic [WordWidth-1:0] crc,
                                                            input logic [ByteWidth-1:0] b);
      logic [WordWidth-1:0] c;
      c = crc ^ {8'h00, b};
      repeat (ByteWidth) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   task automatic model_rearm();
      frame_pos = POS_FUNCTION;
      crc_acc   = CRC_INIT;
      header_ok = 1'b1;
   endtask

   // advance the predicted frame state by one accepted word
   task automatic model_take_byte(input logic [ByteWidth-1:0] b, input logic start);
      reading_type r;
      logic        done;
      done = 1'b0;
      if (start) model_rearm();
      case (frame_pos)
         POS_FUNCTION: begin
            if (b != want_function) header_ok = 1'b0;
            crc_acc = modbus_crc_step(crc_acc, b);
         end
         POS_COUNT: begin
            if (b != want_count) header_ok = 1'b0;
            crc_acc = modbus_crc_step(crc_acc, b);
         end
         POS_HUM_HIGH: begin
            hum_acc[15:8] = b;
            crc_acc = modbus_crc_step(crc_acc, b);
         end
         POS_HUM_LOW: begin
            hum_acc[7:0] = b;
            crc_acc = modbus_crc_step(crc_acc, b);
         end
         POS_TEMP_HIGH: begin
            temp_acc[15:8] = b;
            crc_acc = modbus_crc_step(crc_acc, b);
         end
         POS_TEMP_LOW: begin
            temp_acc[7:0] = b;
            crc_acc = modbus_crc_step(crc_acc, b);
         end
         POS_CRC_LOW: begin
            crc_low_byte = b;
         end
         default: begin
            // header verdict wins over the crc one, words are passed on regardless
            r.humidity    = hum_acc;
            r.temperature = temp_acc;
            if (!header_ok) r.status = STATUS_HEADER_BAD;
            else if ({b, crc_low_byte} != crc_acc) r.status = STATUS_CRC_BAD;
            else r.status = STATUS_OK;
            pending_readings.push_back(r);
            model_rearm();
            done = 1'b1;
         end
      endcase
      if (!done) frame_pos = frame_pos + 1'b1;
   endtask

   // ---------------------------------------------------------------- drivers

   // mostly back to back, sometimes a short gap, now and then a long pause
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // send one reply byte; valid stays high afterwards so words can follow back to back
   task automatic push_byte(input logic [ByteWidth-1:0] b, input logic start);
      int gap;
      gap = req_pauses_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      model_take_byte(b, start);
      bytes_sent++;
   endtask

   // wait for every verdict, then let the pipeline drain bytes that give none
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [IndexWidth-1:0] idx, input logic [ByteWidth-1:0] val);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_EXPECTED_FUNCTION) want_function = val;
      else if (idx == CSR_EXPECTED_COUNT) want_count = val;
   endtask

   // whole 8-byte reply, byte 0 in the lowest bits, crc optionally damaged by flip
   function automatic logic [63:0] frame_image(input logic [ByteWidth-1:0] fn,
                                               input logic [ByteWidth-1:0] cnt,
                                               input logic [WordWidth-1:0] hum,
                                               input logic [WordWidth-1:0] temp,
                                               input logic [WordWidth-1:0] flip);
      logic [47:0]          body;
      logic [WordWidth-1:0] crc;
      body = {temp[7:0], temp[15:8], hum[7:0], hum[15:8], cnt, fn};
      crc  = CRC_INIT;
      for (int i = 0; i < 6; i++) crc = modbus_crc_step(crc, body[8*i +: 8]);
      crc = crc ^ flip;
      return {crc[15:8], crc[7:0], body};
   endfunction

   task automatic send_frame(input logic [63:0] img, input logic start);
      for (int i = 0; i < 8; i++) push_byte(img[8*i +: 8], (i == 0) ? start : 1'b0);
   endtask

   // receiver readiness, stalls of random length when enabled
   always @(posedge clock) begin
      if (!rsp_stalls_on) begin
         rsp_tready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end else begin
         rsp_gap = pick_gap();
         rsp_tready <= (rsp_gap == 0);
         rsp_hold = (rsp_gap == 0) ? $urandom_range(0, 4) : rsp_gap - 1;
      end
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin : reading_check
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: reading with none expected, actual hum %h temp %h status %0d",
                     $time, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser);
            errors++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata[15:0] !== want.humidity) begin
               $display("%0t: humidity expected %h actual %h", $time, want.humidity,
                        rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[31:16] !== want.temperature) begin
               $display("%0t: temperature expected %h actual %h", $time, want.temperature,
                        rsp_tdata[31:16]);
               errors++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // good reply under the reset register values, humidity all ones, temperature zero
   task automatic test_reset_defaults();
      send_frame(frame_image(FUNCTION_RESET, COUNT_RESET, 16'hFFFF, 16'h0000, 16'h0000), 1'b1);
   endtask

   // follows on with no frame begin, bad crc, words must still come through
   task automatic test_crc_mismatch();
      send_frame(frame_image(FUNCTION_RESET, COUNT_RESET, 16'h0000, 16'hFFFF, 16'h8001), 1'b0);
   endtask

   // partial frame dropped by a new frame begin, then both checks fail and header wins
   task automatic test_restart_header_wins();
      push_byte(FUNCTION_RESET, 1'b1);
      push_byte(8'hAA, 1'b0);
      send_frame(frame_image(8'hFF, 8'h00, 16'h1234, 16'hA5C3, 16'h00FF), 1'b1);
   endtask

   // writes past the list are ignored, the count register changes between bytes 0 and 1
   task automatic test_register_writes();
      logic [63:0] img;
      csr_write(CSR_UNUSED_FIRST, 8'h77);
      csr_write(CSR_UNUSED_LAST, 8'h55);
      csr_write(CSR_EXPECTED_FUNCTION, 8'h00);
      img = frame_image(8'h00, 8'hFF, 16'h5A5A, 16'h0180, 16'h0000);
      push_byte(img[7:0], 1'b1);
      csr_write(CSR_EXPECTED_COUNT, 8'hFF);
      for (int i = 1; i < 8; i++) push_byte(img[8*i +: 8], 1'b0);
   endtask

   // one random reply: mostly well formed, some damaged, cut short or plain noise
   task automatic random_frame();
      int                   kind;
      int                   n;
      logic                 start;
      logic [ByteWidth-1:0] fn;
      logic [ByteWidth-1:0] cnt;
      logic [WordWidth-1:0] flip;
      logic [63:0]          img;
      // out of step after noise or a cut frame, so force a fresh start then
      start = (frame_pos != POS_FUNCTION) ? 1'b1 : 1'($urandom_range(0, 1));
      fn    = want_function;
      cnt   = want_count;
      flip  = '0;
      kind  = $urandom_range(0, 99);
      if (kind >= 55 && kind < 68) begin
         case ($urandom_range(0, 2))
            0: fn = fn ^ 8'($urandom_range(1, 255));
            1: cnt = cnt ^ 8'($urandom_range(1, 255));
            default: begin
               fn  = fn ^ 8'($urandom_range(1, 255));
               cnt = cnt ^ 8'($urandom_range(1, 255));
            end
         endcase
         if ($urandom_range(0, 1) == 0) flip = 16'($urandom_range(1, 65535));
      end else if (kind >= 68 && kind < 80) begin
         flip = 16'($urandom_range(1, 65535));
      end
      img = frame_image(fn, cnt, 16'($urandom), 16'($urandom), flip);
      if (kind < 80) begin
         send_frame(img, start);
      end else if (kind < 92) begin
         n = $urandom_range(1, 7);
         for (int i = 0; i < n; i++) push_byte(img[8*i +: 8], (i == 0) ? start : 1'b0);
      end else begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) push_byte(8'($urandom), ($urandom_range(0, 3) == 0));
      end
   endtask

   // phases of random traffic, registers rewritten between phases incl. both extremes
   task automatic test_random_traffic();
      int last_byte;
      int phase_end;
      int phase;
      last_byte = bytes_sent + RandomBytes;
      phase     = 0;
      while (bytes_sent < last_byte) begin
         case (phase % 4)
            0: begin
               csr_write(CSR_EXPECTED_FUNCTION, 8'h00);
               csr_write(CSR_EXPECTED_COUNT, 8'h00);
            end
            1: begin
               csr_write(CSR_EXPECTED_FUNCTION, 8'hFF);
               csr_write(CSR_EXPECTED_COUNT, 8'hFF);
            end
            2: begin
               csr_write(CSR_EXPECTED_FUNCTION, FUNCTION_RESET);
               csr_write(CSR_EXPECTED_COUNT, COUNT_RESET);
            end
            default: begin
               csr_write(CSR_EXPECTED_FUNCTION, 8'($urandom));
               csr_write(CSR_EXPECTED_COUNT, 8'($urandom));
            end
         endcase
         phase_end = bytes_sent + $urandom_range(90, 140);
         while (bytes_sent < phase_end && bytes_sent < last_byte) begin
            // roughly one frame in six runs at full rate on both sides
            req_pauses_on = ($urandom_range(0, 5) != 0);
            rsp_stalls_on = req_pauses_on;
            random_frame();
         end
         phase++;
      end
      req_pauses_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      want_function = FUNCTION_RESET;
      want_count    = COUNT_RESET;
      hum_acc       = '0;
      temp_acc      = '0;
      crc_low_byte  = '0;
      model_rearm();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_crc_mismatch();
      test_restart_header_wins();
      test_register_writes();
      test_random_traffic();

      // drain, then give the block time to show any stray word
      settle();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
